// ----- hw/rtl/salc_pkg.sv -----
// Shared constants, types and register codes of the set-associative LRU tag store.
package salc_pkg;

    localparam int DEF_ADDR_BITS = 32;
    localparam int DEF_SET_BITS  = 6;
    localparam int DEF_WAYS      = 4;

    localparam int ADDR_W  = 32;
    localparam int TAG_W   = 32;
    localparam int STAMP_W = 32;
    localparam int TOT_W   = 32;
    localparam int OCC_W   = 9;
    localparam int SUM_W   = 48;
    localparam int OFF_W   = 5;
    localparam int IDX_W   = 3;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [OFF_W-1:0] OFF_RST = 5'd6;
    localparam logic [IDX_W-1:0] IDX_RST = 3'd6;

    // Register select taken from the word address bit of paddr.
    localparam logic REG_BLOCK_OFFSET = 1'b0;
    localparam logic REG_INDEX        = 1'b1;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    typedef struct packed {
        logic row_rd;
        logic row_wr;
        logic ent_rd;
        logic ent_wr;
    } t_store_ctl;

endpackage

// ----- hw/rtl/salc_if.sv -----
// Request and result channel interfaces of the tag store.
interface salc_req_if import salc_pkg::*;;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output address, input ready);
    modport sink (input valid, input address, output ready);
endinterface

interface salc_rsp_if import salc_pkg::*;;
    logic             valid;
    logic             ready;
    logic             hit;
    logic [1:0]       way;
    logic             filled_empty;
    logic             evicted;
    logic [TOT_W-1:0] access_total;
    logic [TOT_W-1:0] hit_total;
    logic [OCC_W-1:0] occupancy;
    logic [SUM_W-1:0] occupancy_sum;

    modport source (output valid, output hit, output way, output filled_empty,
                    output evicted, output access_total, output hit_total,
                    output occupancy, output occupancy_sum, input ready);
    modport sink (input valid, input hit, input way, input filled_empty,
                  input evicted, input access_total, input hit_total,
                  input occupancy, input occupancy_sum, output ready);
endinterface

// ----- hw/rtl/salc_store.sv -----
// Valid-row memory and tag/stamp entry memory with registered read data.
module salc_store import salc_pkg::*; #(
    parameter int SET_W = DEF_SET_BITS,
    parameter int WAY_W = $clog2(DEF_WAYS),
    parameter int WAYS  = DEF_WAYS
) (
    input  logic                   i_clk,
    input  t_store_ctl             i_ctl,
    input  logic [SET_W-1:0]       i_row_addr,
    input  logic [WAYS-1:0]        i_row_wdata,
    output logic [WAYS-1:0]        o_row_q,
    input  logic [SET_W+WAY_W-1:0] i_ent_raddr,
    input  logic [SET_W+WAY_W-1:0] i_ent_waddr,
    input  t_entry                 i_ent_wdata,
    output t_entry                 o_ent_q
);

    localparam int ROWS      = 1 << SET_W;
    localparam int ENT_DEPTH = 1 << (SET_W + WAY_W);

    logic [WAYS-1:0] r_rows [ROWS];
    t_entry          r_ents [ENT_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_ctl.row_wr) begin
            r_rows[i_row_addr] <= i_row_wdata;
        end
        if (i_ctl.row_rd) begin
            o_row_q <= r_rows[i_row_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ent_wr) begin
            r_ents[i_ent_waddr] <= i_ent_wdata;
        end
        if (i_ctl.ent_rd) begin
            o_ent_q <= r_ents[i_ent_raddr];
        end
    end

endmodule

// ----- hw/rtl/set_assoc_lru_cache_tag_model_unit.sv -----
// A result reaches the output register once its address beat has passed FETCH, SCAN,
// UPDATE and DONE; a new address is taken only in IDLE. The ways of a set are scanned one
// per cycle through the single entry memory read port and one tag/stamp compare.
// A waiting result does not block the next address: the output register parts the sides.
// Reset (synchronous, active low) clears the statistics and then sweeps the valid rows,
// one set per cycle, through every row before the first beat is taken.
module set_assoc_lru_cache_tag_model_unit import salc_pkg::*; #(
    parameter int ADDR_BITS = DEF_ADDR_BITS,
    parameter int SET_BITS  = DEF_SET_BITS,
    parameter int WAYS      = DEF_WAYS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    salc_req_if.sink           i_req,
    salc_rsp_if.source         o_rsp
);

    localparam int SET_W   = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ENTRIES = (1 << SET_BITS) * WAYS;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDR_BITS >= ADDR_W) ? '1 :
        ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(WAYS - 1);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_FETCH  = 6'b000100,
        S_SCAN   = 6'b001000,
        S_UPDATE = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state r_state;

    logic [OFF_W-1:0] r_off;
    logic [IDX_W-1:0] r_idx;

    logic [SET_W-1:0]   r_clr;
    logic [SET_W-1:0]   r_set, n_set;
    logic [TAG_W-1:0]   r_tag, n_tag;
    logic [WAY_W-1:0]   r_cnt;
    logic               r_hit;
    logic [WAY_W-1:0]   r_way;
    logic [STAMP_W-1:0] r_oldest;
    logic [WAY_W-1:0]   r_old_way;
    logic               r_filled;
    logic               r_evicted;

    logic [TOT_W-1:0] r_acc;
    logic [TOT_W-1:0] r_hit_cnt;
    logic [CNT_W-1:0] r_count;
    logic [SUM_W-1:0] r_accum;

    logic             r_out_valid;
    logic             r_o_hit;
    logic [WAY_W-1:0] r_o_way;
    logic             r_o_filled;
    logic             r_o_evicted;
    logic [TOT_W-1:0] r_o_acc;
    logic [TOT_W-1:0] r_o_hits;
    logic [CNT_W-1:0] r_o_occ;
    logic [SUM_W-1:0] r_o_sum;

    logic              accept;
    logic [ADDR_W-1:0] addr_m;
    logic [ADDR_W-1:0] shifted;
    logic [3:0]        idx_eff;
    logic [SET_W-1:0]  set_mask;
    logic [5:0]        tag_sh;

    t_store_ctl       st_ctl;
    logic [SET_W-1:0] row_addr;
    logic [WAYS-1:0]  row_wdata;
    logic [WAYS-1:0]  row_q;
    logic [WAY_W-1:0] rd_way;
    t_entry           ent_q;
    t_entry           ent_wdata;

    logic             way_valid;
    logic             hit_now;
    logic             is_last;
    logic             free_any;
    logic [WAY_W-1:0] free_way;
    logic [WAY_W-1:0] way_sel;
    logic             out_free;
    logic [SUM_W:0]   sum_wide;

    // Configuration port
    assign pready = 1'b1;

    always_comb begin
        unique case (paddr[2])
            REG_BLOCK_OFFSET: prdata = PDATA_W'(r_off);
            REG_INDEX:        prdata = PDATA_W'(r_idx);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off <= OFF_RST;
            r_idx <= IDX_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_BLOCK_OFFSET: r_off <= pwdata[OFF_W-1:0];
                REG_INDEX:        r_idx <= pwdata[IDX_W-1:0];
                default:          ;
            endcase
        end
    end

    // Address split into set and tag
    assign addr_m   = i_req.address & ADDR_MASK;
    assign shifted  = addr_m >> r_off;
    assign idx_eff  = ({1'b0, r_idx} > 4'(SET_BITS)) ? 4'(SET_BITS) : {1'b0, r_idx};
    assign set_mask = ~({SET_W{1'b1}} << idx_eff);
    assign n_set    = shifted[SET_W-1:0] & set_mask;
    assign tag_sh   = 6'(r_off) + 6'(idx_eff);
    // Shifting past the top leaves no tag bits, which gives a zero tag.
    assign n_tag    = addr_m >> tag_sh;

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;

    // Scan of one way per cycle
    assign way_valid = row_q[r_cnt];
    assign hit_now   = way_valid && (ent_q.tag == r_tag);
    assign is_last   = (r_cnt == LAST_WAY);

    always_comb begin
        free_any = 1'b0;
        free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (!row_q[w]) begin
                free_any = 1'b1;
                free_way = WAY_W'(w);
            end
        end
    end

    always_comb begin
        priority if (r_hit) begin
            way_sel = r_way;
        end else if (free_any) begin
            way_sel = free_way;
        end else begin
            way_sel = r_old_way;
        end
    end

    // Store control
    assign rd_way         = (r_state == S_FETCH) ? '0 : r_cnt + WAY_W'(1);
    assign st_ctl.row_rd  = (r_state == S_FETCH);
    assign st_ctl.row_wr  = (r_state == S_CLEAR) || (r_state == S_UPDATE);
    assign st_ctl.ent_rd  = (r_state == S_FETCH) || ((r_state == S_SCAN) && !hit_now && !is_last);
    assign st_ctl.ent_wr  = (r_state == S_UPDATE);
    assign row_addr       = (r_state == S_CLEAR) ? r_clr : r_set;
    assign row_wdata      = (r_state == S_CLEAR) ? '0 : (row_q | (WAYS'(1) << way_sel));
    assign ent_wdata.tag   = r_tag;
    assign ent_wdata.stamp = r_acc;

    salc_store #(
        .SET_W (SET_W),
        .WAY_W (WAY_W),
        .WAYS  (WAYS)
    ) u_store (
        .i_clk       (i_clk),
        .i_ctl       (st_ctl),
        .i_row_addr  (row_addr),
        .i_row_wdata (row_wdata),
        .o_row_q     (row_q),
        .i_ent_raddr ({r_set, rd_way}),
        .i_ent_waddr ({r_set, way_sel}),
        .i_ent_wdata (ent_wdata),
        .o_ent_q     (ent_q)
    );

    assign out_free = !r_out_valid || o_rsp.ready;
    assign sum_wide = {1'b0, r_accum} + (SUM_W + 1)'(r_count);

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_acc       <= '0;
            r_hit_cnt   <= '0;
            r_count     <= '0;
            r_accum     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + SET_W'(1);
                    if (r_clr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_set   <= n_set;
                        r_tag   <= n_tag;
                        r_acc   <= (r_acc == '1) ? r_acc : r_acc + TOT_W'(1);
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    r_cnt   <= '0;
                    r_hit   <= 1'b0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (hit_now) begin
                        r_hit   <= 1'b1;
                        r_way   <= r_cnt;
                        r_state <= S_UPDATE;
                    end else begin
                        // Strict compare keeps the lowest way among equal stamps.
                        if ((r_cnt == '0) || (ent_q.stamp < r_oldest)) begin
                            r_oldest  <= ent_q.stamp;
                            r_old_way <= r_cnt;
                        end
                        if (is_last) begin
                            r_state <= S_UPDATE;
                        end else begin
                            r_cnt <= r_cnt + WAY_W'(1);
                        end
                    end
                end
                S_UPDATE: begin
                    r_way     <= way_sel;
                    r_filled  <= !r_hit && free_any;
                    r_evicted <= !r_hit && !free_any;
                    if (r_hit) begin
                        r_hit_cnt <= (r_hit_cnt == '1) ? r_hit_cnt : r_hit_cnt + TOT_W'(1);
                    end else if (free_any) begin
                        r_count <= r_count + CNT_W'(1);
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_accum <= sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                    r_clr   <= '0;
                end
            endcase
        end
    end

    // Result beat payload
    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_o_hit     <= r_hit;
            r_o_way     <= r_way;
            r_o_filled  <= r_filled;
            r_o_evicted <= r_evicted;
            r_o_acc     <= r_acc;
            r_o_hits    <= r_hit_cnt;
            r_o_occ     <= r_count;
            r_o_sum     <= sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.hit           = r_o_hit;
    assign o_rsp.way           = 2'(r_o_way);
    assign o_rsp.filled_empty  = r_o_filled;
    assign o_rsp.evicted       = r_o_evicted;
    assign o_rsp.access_total  = r_o_acc;
    assign o_rsp.hit_total     = r_o_hits;
    assign o_rsp.occupancy     = OCC_W'(r_o_occ);
    assign o_rsp.occupancy_sum = r_o_sum;

endmodule
